// ----- rtl/core/msspr_pkg.sv -----
`default_nettype none
package msspr_pkg;

  // field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned INDEX_W  = 3;
  localparam int unsigned TARGET_W = 18;
  localparam int unsigned SPEED_W  = 24;
  localparam int unsigned ANGLE_W  = 17;
  localparam int unsigned PULSE_W  = 16;

  // angle fixed point: 65536 is pi/2, 32768 is pi/4
  localparam logic [ANGLE_W-1:0] ANGLE_FULL  = 17'd65536;
  localparam logic [ANGLE_W-1:0] ANGLE_RESET = 17'd32768;

  // floor(speed / 50) as speed * RECIP >> RECIP_SHIFT, exact for 24-bit speeds
  localparam int unsigned RECIP_W     = 25;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP = 25'd21474837;
  localparam int unsigned PROD_W  = SPEED_W + RECIP_W;
  localparam int unsigned DELTA_W = 19;

  // servo parameter entry: target angle above, step below
  localparam int unsigned PARAM_W = ANGLE_W + DELTA_W;

  localparam int unsigned SERVO_COUNT_DEF = 6;
  localparam int unsigned MAX_RESULTS     = 6;

  // configuration registers
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_PULSE_MIN = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PULSE_MAX = 1'd1;
  localparam logic [PULSE_W-1:0] PULSE_MIN_RESET = 16'd1000;
  localparam logic [PULSE_W-1:0] PULSE_MAX_RESET = 16'd2000;

  typedef enum logic [OP_W-1:0] {
    OP_SET  = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SET_WR,
    S_RD,
    S_CALC,
    S_MUL,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/msspr_mem.sv -----
`default_nettype none
module msspr_mem #(
  parameter int unsigned DEPTH  = 6,
  parameter int unsigned ADDR_W = 3,
  parameter int unsigned WIDTH  = 17,
  parameter logic [WIDTH-1:0] RESET_VAL = '0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              re,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [WIDTH-1:0]  wdata,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [WIDTH-1:0] rdata_r;
  logic             rvalid_r;

  // entry never written reads as its reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r  <= mem[addr];
      rvalid_r <= valid_r[addr];
    end
  end

  assign rdata = rvalid_r ? rdata_r : RESET_VAL;

endmodule
`default_nettype wire

// ----- rtl/core/msspr_pulse.sv -----
`default_nettype none
module msspr_pulse (
  input  wire logic                          clk,
  input  wire logic                          load,
  input  wire logic [msspr_pkg::ANGLE_W-1:0] angle,
  input  wire logic [msspr_pkg::PULSE_W-1:0] pulse_min,
  input  wire logic [msspr_pkg::PULSE_W-1:0] pulse_max,
  output logic      [msspr_pkg::PULSE_W-1:0] pulse
);

  localparam int unsigned DIFF_W = msspr_pkg::PULSE_W + 1;
  localparam int unsigned MUL_W  = msspr_pkg::ANGLE_W + 1 + DIFF_W;

  logic signed [DIFF_W-1:0] diff;
  logic signed [msspr_pkg::ANGLE_W:0] angle_s;
  logic signed [MUL_W-1:0] prod_nxt;
  logic signed [MUL_W-1:0] prod_r;

  assign diff     = $signed({1'b0, pulse_max}) - $signed({1'b0, pulse_min});
  assign angle_s  = $signed({1'b0, angle});
  assign prod_nxt = MUL_W'(angle_s) * MUL_W'(diff);

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

  // arithmetic shift by 16 floors negative products, keep the low 16 bits
  assign pulse = pulse_min + prod_r[msspr_pkg::PULSE_W+15:16];

endmodule
`default_nettype wire

// ----- rtl/core/msspr_ctrl.sv -----
`default_nettype none
module msspr_ctrl #(
  parameter int unsigned SERVO_COUNT = msspr_pkg::SERVO_COUNT_DEF,
  parameter int unsigned ADDR_W      = 3,
  parameter int unsigned CNT_W       = 3
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [msspr_pkg::OP_W-1:0]     in_operation,
  input  wire logic [msspr_pkg::INDEX_W-1:0]  in_servo_index,
  input  wire logic signed [msspr_pkg::TARGET_W-1:0] in_target_angle,
  input  wire logic [msspr_pkg::SPEED_W-1:0]  in_speed,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [msspr_pkg::INDEX_W-1:0]  out_servo_number,
  output logic      [msspr_pkg::ANGLE_W-1:0]  out_angle_now,
  output logic      [msspr_pkg::PULSE_W-1:0]  out_pulse_width,
  output logic                                out_moving,
  output logic                                out_last,
  output logic                                mem_re,
  output logic      [ADDR_W-1:0]              mem_addr,
  output logic                                ang_we,
  output logic      [msspr_pkg::ANGLE_W-1:0]  ang_wdata,
  input  wire logic [msspr_pkg::ANGLE_W-1:0]  ang_rdata,
  output logic                                par_we,
  output logic      [msspr_pkg::PARAM_W-1:0]  par_wdata,
  input  wire logic [msspr_pkg::PARAM_W-1:0]  par_rdata,
  output logic                                pulse_load,
  output logic      [msspr_pkg::ANGLE_W-1:0]  pulse_angle,
  input  wire logic [msspr_pkg::PULSE_W-1:0]  pulse_value
);

  localparam int unsigned N_REPORT = (SERVO_COUNT < msspr_pkg::MAX_RESULTS) ?
                                     SERVO_COUNT : msspr_pkg::MAX_RESULTS;
  localparam int unsigned AW = msspr_pkg::ANGLE_W;
  localparam int unsigned DW = msspr_pkg::DELTA_W;
  localparam int unsigned SUM_W = DW + 1;

  msspr_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             is_tick_r;
  logic             bad_r;
  logic [msspr_pkg::INDEX_W-1:0] idx_r;
  logic [AW-1:0]    tgt_r;
  logic [msspr_pkg::PROD_W-1:0] dprod_r;
  logic [AW-1:0]    angle_r;
  logic             moving_r;
  logic             out_valid_r;
  logic [msspr_pkg::INDEX_W-1:0] out_num_r;
  logic [AW-1:0]    out_angle_r;
  logic [msspr_pkg::PULSE_W-1:0] out_pulse_r;
  logic             out_moving_r;
  logic             out_last_r;

  logic             accept;
  logic             idx_ok;
  logic [AW-1:0]    tgt_clamp;
  logic             out_free;
  logic             emit_fire;
  logic             last_servo;
  logic             skip_report;
  logic             advance;
  logic [AW-1:0]    cur, tgt, next_angle;
  logic [DW-1:0]    delta;
  logic [SUM_W-1:0] gap_up, gap_dn;

  assign in_ready = (state_r == msspr_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign idx_ok   = ({2'b00, in_servo_index} < 5'(SERVO_COUNT));
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    if (in_target_angle[msspr_pkg::TARGET_W-1]) begin
      tgt_clamp = '0;
    end else if (in_target_angle[AW-1:0] > msspr_pkg::ANGLE_FULL) begin
      tgt_clamp = msspr_pkg::ANGLE_FULL;
    end else begin
      tgt_clamp = in_target_angle[AW-1:0];
    end
  end

  // step toward target, stop on it
  assign cur    = ang_rdata;
  assign tgt    = par_rdata[msspr_pkg::PARAM_W-1:DW];
  assign delta  = par_rdata[DW-1:0];
  assign gap_up = SUM_W'(tgt) - SUM_W'(cur);
  assign gap_dn = SUM_W'(cur) - SUM_W'(tgt);

  always_comb begin
    if (!is_tick_r || cur == tgt) begin
      next_angle = cur;
    end else if (cur < tgt) begin
      if (SUM_W'(delta) >= gap_up) begin
        next_angle = tgt;
      end else begin
        next_angle = AW'(SUM_W'(cur) + SUM_W'(delta));
      end
    end else begin
      if (SUM_W'(delta) >= gap_dn) begin
        next_angle = tgt;
      end else begin
        next_angle = AW'(SUM_W'(cur) - SUM_W'(delta));
      end
    end
  end

  assign last_servo  = (cnt_r == CNT_W'(SERVO_COUNT - 1));
  assign skip_report = is_tick_r && (cnt_r >= CNT_W'(N_REPORT));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      msspr_pkg::S_IDLE: begin
        if (accept) begin
          case (in_operation)
            msspr_pkg::OP_SET:  state_nxt = idx_ok ? msspr_pkg::S_SET_WR : msspr_pkg::S_IDLE;
            msspr_pkg::OP_TICK: state_nxt = msspr_pkg::S_RD;
            msspr_pkg::OP_READ: state_nxt = idx_ok ? msspr_pkg::S_RD : msspr_pkg::S_EMIT;
            default:            state_nxt = msspr_pkg::S_IDLE;
          endcase
        end
      end
      msspr_pkg::S_SET_WR: state_nxt = msspr_pkg::S_IDLE;
      msspr_pkg::S_RD:     state_nxt = msspr_pkg::S_CALC;
      msspr_pkg::S_CALC: begin
        if (!skip_report) begin
          state_nxt = msspr_pkg::S_MUL;
        end else if (last_servo) begin
          state_nxt = msspr_pkg::S_IDLE;
        end else begin
          state_nxt = msspr_pkg::S_RD;
        end
      end
      msspr_pkg::S_MUL: state_nxt = msspr_pkg::S_EMIT;
      msspr_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = (is_tick_r && !last_servo) ? msspr_pkg::S_RD : msspr_pkg::S_IDLE;
        end
      end
      default: state_nxt = msspr_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    mem_re     = 1'b0;
    ang_we     = 1'b0;
    par_we     = 1'b0;
    pulse_load = 1'b0;
    emit_fire  = 1'b0;
    advance    = 1'b0;
    unique case (state_r)
      msspr_pkg::S_IDLE:   ;
      msspr_pkg::S_SET_WR: par_we = 1'b1;
      msspr_pkg::S_RD:     mem_re = 1'b1;
      msspr_pkg::S_CALC: begin
        ang_we  = is_tick_r;
        advance = skip_report && !last_servo;
      end
      msspr_pkg::S_MUL:    pulse_load = 1'b1;
      msspr_pkg::S_EMIT: begin
        emit_fire = out_free;
        advance   = out_free && is_tick_r && !last_servo;
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_operation == msspr_pkg::OP_TICK || !idx_ok) begin
        cnt_nxt = '0;
      end else begin
        cnt_nxt = CNT_W'(in_servo_index);
      end
    end else if (advance) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  assign mem_addr    = cnt_r[ADDR_W-1:0];
  assign ang_wdata   = next_angle;
  assign par_wdata   = {tgt_r, dprod_r[msspr_pkg::PROD_W-1:msspr_pkg::RECIP_SHIFT]};
  assign pulse_angle = angle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msspr_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= emit_fire || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_tick_r <= (in_operation == msspr_pkg::OP_TICK);
      // a tick ignores the servo index
      bad_r     <= (in_operation != msspr_pkg::OP_TICK) && !idx_ok;
      idx_r     <= in_servo_index;
      tgt_r     <= tgt_clamp;
      dprod_r   <= msspr_pkg::PROD_W'(in_speed) * msspr_pkg::PROD_W'(msspr_pkg::RECIP);
    end
    if (state_r == msspr_pkg::S_CALC) begin
      angle_r  <= next_angle;
      moving_r <= (next_angle != tgt);
    end
    if (emit_fire) begin
      out_num_r    <= is_tick_r ? msspr_pkg::INDEX_W'(cnt_r) : idx_r;
      out_angle_r  <= bad_r ? '0 : angle_r;
      out_pulse_r  <= bad_r ? '0 : pulse_value;
      out_moving_r <= !bad_r && moving_r;
      out_last_r   <= !is_tick_r || (cnt_r == CNT_W'(N_REPORT - 1));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_servo_number = out_num_r;
  assign out_angle_now    = out_angle_r;
  assign out_pulse_width  = out_pulse_r;
  assign out_moving       = out_moving_r;
  assign out_last         = out_last_r;

endmodule
`default_nettype wire

// ----- rtl/core/multi_servo_slew_ramp_pwm_top.sv -----
// Slew-rate limited servo ramp with PWM compare output. Each servo keeps a
// current angle, a target angle and a step (floor(speed/50), computed when the
// target is set); angles are fixed point with 0..65536 for 0..pi/2 and reset
// to 32768. A set request (operation 0) clamps the target to 0..65536; a set
// to a servo that does not exist is dropped. A read request (operation 2)
// gives one result; a read of a missing servo gives zeros with its index. A
// tick request (operation 1) steps every servo toward its target and reports
// the first six in order, last flagged. In a tick each servo is read from the
// two state memories and its new angle is written back, and a reported servo
// then passes through the registered pulse multiplier before its result goes
// out; requests are handled one at a time. Pulse is
// pulse_min + floor(angle*(pulse_max-pulse_min)/65536), so reversed limits
// give a falling pulse. Write pulse_min/pulse_max only while idle. Output
// stalls hold the block without loss.
`default_nettype none
module multi_servo_slew_ramp_pwm_top #(
  parameter int unsigned SERVO_COUNT = msspr_pkg::SERVO_COUNT_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // request channel
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [msspr_pkg::OP_W-1:0]            in_operation,
  input  wire logic [msspr_pkg::INDEX_W-1:0]         in_servo_index,
  input  wire logic signed [msspr_pkg::TARGET_W-1:0] in_target_angle,
  input  wire logic [msspr_pkg::SPEED_W-1:0]         in_speed,
  // result channel
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic      [msspr_pkg::INDEX_W-1:0]         out_servo_number,
  output logic      [msspr_pkg::ANGLE_W-1:0]         out_angle_now,
  output logic      [msspr_pkg::PULSE_W-1:0]         out_pulse_width,
  output logic                                       out_moving,
  output logic                                       out_last,
  // configuration writes
  input  wire logic                                  cfg_we,
  input  wire logic [msspr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [msspr_pkg::PULSE_W-1:0]         cfg_wdata
);

  // servo address and counter widths, counter can also hold the count itself
  localparam int unsigned ADDR_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
  localparam int unsigned CNT_W  = $clog2(SERVO_COUNT + 1);

  logic [msspr_pkg::PULSE_W-1:0] pulse_min_r;
  logic [msspr_pkg::PULSE_W-1:0] pulse_max_r;

  logic                          mem_re;
  logic [ADDR_W-1:0]             mem_addr;
  logic                          ang_we;
  logic [msspr_pkg::ANGLE_W-1:0] ang_wdata;
  logic [msspr_pkg::ANGLE_W-1:0] ang_rdata;
  logic                          par_we;
  logic [msspr_pkg::PARAM_W-1:0] par_wdata;
  logic [msspr_pkg::PARAM_W-1:0] par_rdata;
  logic                          pulse_load;
  logic [msspr_pkg::ANGLE_W-1:0] pulse_angle;
  logic [msspr_pkg::PULSE_W-1:0] pulse_value;

  // pulse limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_min_r <= msspr_pkg::PULSE_MIN_RESET;
      pulse_max_r <= msspr_pkg::PULSE_MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        msspr_pkg::REG_PULSE_MIN: pulse_min_r <= cfg_wdata;
        msspr_pkg::REG_PULSE_MAX: pulse_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // current angles
  msspr_mem #(
    .DEPTH     (SERVO_COUNT),
    .ADDR_W    (ADDR_W),
    .WIDTH     (msspr_pkg::ANGLE_W),
    .RESET_VAL (msspr_pkg::ANGLE_RESET)
  ) u_angle_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (mem_re),
    .we    (ang_we),
    .addr  (mem_addr),
    .wdata (ang_wdata),
    .rdata (ang_rdata)
  );

  // target angle and step per servo
  msspr_mem #(
    .DEPTH     (SERVO_COUNT),
    .ADDR_W    (ADDR_W),
    .WIDTH     (msspr_pkg::PARAM_W),
    .RESET_VAL ({msspr_pkg::ANGLE_RESET, {msspr_pkg::DELTA_W{1'b0}}})
  ) u_param_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (mem_re),
    .we    (par_we),
    .addr  (mem_addr),
    .wdata (par_wdata),
    .rdata (par_rdata)
  );

  // registered angle times pulse span
  msspr_pulse u_pulse (
    .clk       (clk),
    .load      (pulse_load),
    .angle     (pulse_angle),
    .pulse_min (pulse_min_r),
    .pulse_max (pulse_max_r),
    .pulse     (pulse_value)
  );

  // request sequencer, slew step and result register
  msspr_ctrl #(
    .SERVO_COUNT (SERVO_COUNT),
    .ADDR_W      (ADDR_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_servo_index   (in_servo_index),
    .in_target_angle  (in_target_angle),
    .in_speed         (in_speed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_servo_number (out_servo_number),
    .out_angle_now    (out_angle_now),
    .out_pulse_width  (out_pulse_width),
    .out_moving       (out_moving),
    .out_last         (out_last),
    .mem_re           (mem_re),
    .mem_addr         (mem_addr),
    .ang_we           (ang_we),
    .ang_wdata        (ang_wdata),
    .ang_rdata        (ang_rdata),
    .par_we           (par_we),
    .par_wdata        (par_wdata),
    .par_rdata        (par_rdata),
    .pulse_load       (pulse_load),
    .pulse_angle      (pulse_angle),
    .pulse_value      (pulse_value)
  );

endmodule
`default_nettype wire

// ----- tb/tb_multi_servo_slew_ramp_pwm_top.sv -----
`default_nettype none
module tb_multi_servo_slew_ramp_pwm_top;
  timeunit 1ns;
  timeprecision 1ps;

  import msspr_pkg::*;

  localparam int CLK_PERIOD       = 10;
  localparam int SERVO_COUNT      = SERVO_COUNT_DEF;
  localparam int REPORTS_PER_TICK = (SERVO_COUNT < MAX_RESULTS) ? SERVO_COUNT : MAX_RESULTS;
  // ramp step per tick is speed divided by the control rate
  localparam int TICK_RATE        = 50;
  // the one operation code the block has no use for
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int DIRECTED_ROWS   = 24;
  localparam int LIMIT_PHASES    = 8;
  localparam int ITEMS_PER_PHASE = 22;
  localparam int RANDOM_PHASE    = 6;
  localparam int HOLD_OFF_PHASE  = 2;
  localparam int HOLD_OFF_CYCLES = 300;
  // leave margin after the last report before touching the limits
  localparam int SETTLE_CYCLES   = 40;
  localparam int CYCLE_LIMIT     = 400000;

  typedef struct packed {
    logic [OP_W-1:0]            op;
    logic [INDEX_W-1:0]         index;
    logic signed [TARGET_W-1:0] target;
    logic [SPEED_W-1:0]         speed;
  } servo_request_t;

  typedef struct packed {
    logic [INDEX_W-1:0] servo_number;
    logic [ANGLE_W-1:0] angle_now;
    logic [PULSE_W-1:0] pulse_width;
    logic               moving;
    logic               last;
  } servo_report_t;

  // one row of the directed table: a request and, where obvious, its report
  typedef struct packed {
    servo_request_t rq;
    logic           typed;
    servo_report_t  report;
  } directed_row_t;

  typedef enum {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_EVERY_THIRD
  } rx_mode_t;

  // dut ports
  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [OP_W-1:0] in_operation;
  logic [INDEX_W-1:0] in_servo_index;
  logic signed [TARGET_W-1:0] in_target_angle;
  logic [SPEED_W-1:0] in_speed;
  logic out_valid;
  logic out_ready;
  logic [INDEX_W-1:0] out_servo_number;
  logic [ANGLE_W-1:0] out_angle_now;
  logic [PULSE_W-1:0] out_pulse_width;
  logic out_moving;
  logic out_last;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [PULSE_W-1:0] cfg_wdata;

  // predicted servo state and limit registers
  logic [ANGLE_W-1:0] servo_angle [SERVO_COUNT];
  logic [ANGLE_W-1:0] servo_target [SERVO_COUNT];
  logic [SPEED_W-1:0] servo_speed [SERVO_COUNT];
  logic [PULSE_W-1:0] pulse_lo;
  logic [PULSE_W-1:0] pulse_hi;

  // reports still owed by the block, oldest first
  servo_report_t pending_reports [$];
  directed_row_t directed_plan [DIRECTED_ROWS];

  int error_count = 0;
  int reports_checked = 0;
  int sets_done = 0;
  int ticks_done = 0;
  int reads_done = 0;
  int cycle_count = 0;
  int burst_left = 8;
  int hold_off_asked = 0;

  // pulse limits per phase; phase 0 keeps the reset values
  int unsigned limit_lo [LIMIT_PHASES] = '{1000, 0, 65535, 1234, 0, 65535, 0, 2000};
  int unsigned limit_hi [LIMIT_PHASES] = '{2000, 65535, 0, 1234, 0, 65535, 0, 1000};

  multi_servo_slew_ramp_pwm_top #(
    .SERVO_COUNT(SERVO_COUNT)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_servo_index   (in_servo_index),
    .in_target_angle  (in_target_angle),
    .in_speed         (in_speed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_servo_number (out_servo_number),
    .out_angle_now    (out_angle_now),
    .out_pulse_width  (out_pulse_width),
    .out_moving       (out_moving),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // compare value: lower limit plus the angle share of the span, floor rounded
  function automatic logic [PULSE_W-1:0] pulse_for_angle(input logic [ANGLE_W-1:0] angle);
    longint span;
    longint total;
    span  = longint'(pulse_hi) - longint'(pulse_lo);
    total = longint'(pulse_lo) + ((longint'(angle) * span) >>> 16);
    return total[PULSE_W-1:0];
  endfunction

  // apply one accepted request to the predicted state, queue its reports
  function automatic void predict_request(input servo_request_t rq, input logic record);
    logic signed [TARGET_W-1:0] raw;
    int clamped;
    int cur;
    int tgt;
    int stride;
    int moved;
    servo_report_t rep;
    case (rq.op)
      OP_SET: begin
        raw = rq.target;
        clamped = raw;
        if (clamped < 0) clamped = 0;
        if (clamped > int'(ANGLE_FULL)) clamped = int'(ANGLE_FULL);
        // a set to a missing servo is dropped
        if (rq.index < SERVO_COUNT) begin
          servo_target[rq.index] = clamped;
          servo_speed[rq.index] = rq.speed;
        end
        sets_done++;
      end
      OP_TICK: begin
        for (int s = 0; s < SERVO_COUNT; s++) begin
          cur = servo_angle[s];
          tgt = servo_target[s];
          stride = servo_speed[s] / TICK_RATE;
          if (cur < tgt) moved = (cur + stride >= tgt) ? tgt : cur + stride;
          else if (cur > tgt) moved = (cur - stride <= tgt) ? tgt : cur - stride;
          else moved = cur;
          servo_angle[s] = moved;
        end
        for (int s = 0; s < REPORTS_PER_TICK; s++) begin
          rep.servo_number = s;
          rep.angle_now = servo_angle[s];
          rep.pulse_width = pulse_for_angle(servo_angle[s]);
          rep.moving = servo_angle[s] != servo_target[s];
          rep.last = s == REPORTS_PER_TICK - 1;
          if (record) pending_reports.push_back(rep);
        end
        ticks_done++;
      end
      OP_READ: begin
        rep.servo_number = rq.index;
        rep.last = 1'b1;
        if (rq.index < SERVO_COUNT) begin
          rep.angle_now = servo_angle[rq.index];
          rep.pulse_width = pulse_for_angle(servo_angle[rq.index]);
          rep.moving = servo_angle[rq.index] != servo_target[rq.index];
        end else begin
          rep.angle_now = '0;
          rep.pulse_width = '0;
          rep.moving = 1'b0;
        end
        if (record) pending_reports.push_back(rep);
        reads_done++;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic directed_row_t plan_row(input logic [OP_W-1:0] op,
                                             input logic [INDEX_W-1:0] index,
                                             input logic signed [TARGET_W-1:0] target,
                                             input logic [SPEED_W-1:0] speed);
    directed_row_t row;
    row = '0;
    row.rq.op = op;
    row.rq.index = index;
    row.rq.target = target;
    row.rq.speed = speed;
    return row;
  endfunction

  // read whose report is known up front
  function automatic directed_row_t read_row(input logic [INDEX_W-1:0] index,
                                             input logic [ANGLE_W-1:0] angle,
                                             input logic [PULSE_W-1:0] pulse,
                                             input logic moving);
    directed_row_t row;
    row = plan_row(OP_READ, index, '0, '0);
    row.typed = 1'b1;
    row.report.servo_number = index;
    row.report.angle_now = angle;
    row.report.pulse_width = pulse;
    row.report.moving = moving;
    row.report.last = 1'b1;
    return row;
  endfunction

  // mostly well-formed requests with in-range content, some noise and extremes
  function automatic servo_request_t random_request();
    servo_request_t rq;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) rq.op = OP_SET;
    else if (pick < 72) rq.op = OP_TICK;
    else if (pick < 95) rq.op = OP_READ;
    else rq.op = OP_UNUSED;
    rq.index = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
    case ($urandom_range(0, 9))
      0: rq.target = $urandom;
      1: rq.target = 18'sh20000;
      2: rq.target = 18'sh1FFFF;
      3: rq.target = $urandom_range(0, 1) ? 65537 : 65536;
      4: rq.target = 0;
      default: rq.target = $urandom_range(0, 65536);
    endcase
    case ($urandom_range(0, 7))
      0: rq.speed = $urandom;
      1: rq.speed = $urandom_range(0, 49);
      default: rq.speed = $urandom_range(50, 400000);
    endcase
    return rq;
  endfunction

  // offer one request, hold it until taken, then maybe pause the sender
  task automatic issue(input servo_request_t rq, input logic typed,
                       input servo_report_t typed_report);
    in_valid <= 1'b1;
    in_operation <= rq.op;
    in_servo_index <= rq.index;
    in_target_angle <= rq.target;
    in_speed <= rq.speed;
    do @(posedge clk); while (!in_ready);
    predict_request(rq, !typed);
    if (typed) pending_reports.push_back(typed_report);
    if (burst_left == 0) begin
      // gap between bursts, with junk on the idle payload
      in_valid <= 1'b0;
      in_operation <= $urandom;
      in_servo_index <= $urandom;
      in_target_angle <= $urandom;
      in_speed <= $urandom;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end else begin
      burst_left--;
    end
  endtask

  // stop sending and let every owed report come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both limit registers, back to back, block idle
  task automatic program_limits(input logic [PULSE_W-1:0] lo, input logic [PULSE_W-1:0] hi);
    cfg_we <= 1'b1;
    cfg_index <= REG_PULSE_MIN;
    cfg_wdata <= lo;
    @(posedge clk);
    pulse_lo = lo;
    cfg_index <= REG_PULSE_MAX;
    cfg_wdata <= hi;
    @(posedge clk);
    pulse_hi = hi;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(input string what, input int expected, input int actual);
    if (expected != actual) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, expected, actual);
    end
  endtask

  // stimulus
  initial begin
    servo_request_t rq;
    logic [PULSE_W-1:0] lo;
    logic [PULSE_W-1:0] hi;
    int effective;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = '0;
    in_servo_index = '0;
    in_target_angle = '0;
    in_speed = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;

    // predicted state after reset
    pulse_lo = PULSE_MIN_RESET;
    pulse_hi = PULSE_MAX_RESET;
    for (int s = 0; s < SERVO_COUNT; s++) begin
      servo_angle[s] = ANGLE_RESET;
      servo_target[s] = ANGLE_RESET;
      servo_speed[s] = '0;
    end

    // directed table, reset limits 1000..2000
    // reset angle is a quarter pi, so the pulse sits mid span
    directed_plan[0]  = read_row(3'd0, 17'd32768, 16'd1500, 1'b0);
    directed_plan[1]  = read_row(3'd5, 17'd32768, 16'd1500, 1'b0);
    // reads past the last servo give zeros and echo the index
    directed_plan[2]  = read_row(3'd6, 17'd0, 16'd0, 1'b0);
    directed_plan[3]  = read_row(3'd7, 17'd0, 16'd0, 1'b0);
    directed_plan[4]  = plan_row(OP_TICK, 3'd0, '0, '0);
    // largest target and top speed: clamps to full scale, one tick gets there
    directed_plan[5]  = plan_row(OP_SET, 3'd0, 18'sh1FFFF, 24'hFFFFFF);
    // most negative target clamps to zero
    directed_plan[6]  = plan_row(OP_SET, 3'd1, 18'sh20000, 24'hFFFFFF);
    // speed under the rate: step of zero, servo stays flagged as moving
    directed_plan[7]  = plan_row(OP_SET, 3'd2, 18'sd40000, 24'd49);
    // downward ramp, limited like an upward one
    directed_plan[8]  = plan_row(OP_SET, 3'd3, 18'sd0, 24'd5000);
    directed_plan[9]  = plan_row(OP_SET, 3'd4, 18'sd65536, 24'd100000);
    // sets to missing servos are dropped
    directed_plan[10] = plan_row(OP_SET, 3'd6, 18'sd1000, 24'd1000);
    directed_plan[11] = plan_row(OP_SET, 3'd7, 18'sd2000, 24'd2000);
    directed_plan[12] = plan_row(OP_UNUSED, 3'd7, 18'sh3FFFF, 24'hFFFFFF);
    directed_plan[13] = plan_row(OP_TICK, 3'd0, '0, '0);
    directed_plan[14] = read_row(3'd0, 17'd65536, 16'd2000, 1'b0);
    directed_plan[15] = read_row(3'd1, 17'd0, 16'd1000, 1'b0);
    directed_plan[16] = plan_row(OP_READ, 3'd2, '0, '0);
    directed_plan[17] = plan_row(OP_TICK, 3'd0, '0, '0);
    directed_plan[18] = plan_row(OP_READ, 3'd3, '0, '0);
    directed_plan[19] = plan_row(OP_SET, 3'd5, 18'sd65535, 24'd0);
    directed_plan[20] = plan_row(OP_TICK, 3'd0, '0, '0);
    // reverse a servo mid ramp
    directed_plan[21] = plan_row(OP_SET, 3'd3, 18'sd32768, 24'hFFFFFF);
    directed_plan[22] = plan_row(OP_TICK, 3'd0, '0, '0);
    directed_plan[23] = plan_row(OP_READ, 3'd4, '0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < LIMIT_PHASES; ph++) begin
      if (ph == 0) begin
        for (int r = 0; r < DIRECTED_ROWS; r++)
          issue(directed_plan[r].rq, directed_plan[r].typed, directed_plan[r].report);
      end else begin
        // limits change only with the block drained
        wait_idle();
        lo = limit_lo[ph];
        hi = limit_hi[ph];
        if (ph == RANDOM_PHASE) begin
          lo = $urandom_range(0, 65535);
          hi = $urandom_range(0, 65535);
        end
        program_limits(lo, hi);
      end
      // receiver goes quiet for a while, requests keep coming
      if (ph == HOLD_OFF_PHASE) hold_off_asked++;
      effective = 0;
      while (effective < ITEMS_PER_PHASE) begin
        rq = random_request();
        issue(rq, 1'b0, '0);
        if (rq.op != OP_UNUSED && !(rq.op == OP_SET && rq.index >= SERVO_COUNT))
          effective++;
      end
    end

    wait_idle();
    $display("run covered %0d sets, %0d ticks and %0d reads over %0d pulse limit settings,",
             sets_done, ticks_done, reads_done, LIMIT_PHASES);
    $display("with %0d servo reports checked and a %0d-cycle result hold-off backing up requests",
             reports_checked, HOLD_OFF_CYCLES);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // result side: own stall pattern, plus one long hold-off when asked
  initial begin
    rx_mode_t mode;
    int mode_left;
    int third;
    int stall_left;
    int hold_off_taken;
    out_ready = 1'b0;
    mode = RX_OPEN;
    mode_left = 0;
    third = 0;
    stall_left = 0;
    hold_off_taken = 0;
    forever begin
      @(posedge clk);
      if (hold_off_taken != hold_off_asked) begin
        hold_off_taken = hold_off_asked;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        case (mode)
          RX_OPEN: out_ready <= 1'b1;
          RX_COIN: out_ready <= $urandom_range(0, 1);
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default: begin
            third = (third + 1) % 3;
            out_ready <= (third == 0);
          end
        endcase
      end
    end
  end

  // report checker: each accepted report against the oldest owed one
  always @(posedge clk) begin
    servo_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        error_count++;
        $display("%0t: unexpected report, expected none, actual servo %0d angle %0d pulse %0d",
                 $time, out_servo_number, out_angle_now, out_pulse_width);
      end else begin
        want = pending_reports.pop_front();
        check_field("servo_number", want.servo_number, out_servo_number);
        check_field("angle_now", want.angle_now, out_angle_now);
        check_field("pulse_width", want.pulse_width, out_pulse_width);
        check_field("moving", want.moving, out_moving);
        check_field("last", want.last, out_last);
        reports_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports still owed",
               cycle_count, pending_reports.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
`default_nettype wire
